@@ hdl/afsp_pkg.sv @@
// Shared types, constants and header field helpers for the ADTS frame sync parser.
`default_nettype none

package afsp_pkg;

    localparam int BYTE_W     = 8;
    localparam int HDR_W      = 56;
    localparam int LEN_W      = 13;
    localparam int FULL_W     = 11;
    localparam int SFI_W      = 4;
    localparam int RATE_W     = 17;
    localparam int BITRATE_W  = 23;
    localparam int FNUM_W     = 16;
    localparam int CFG_W      = 8;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0]        SYNC_MASK     = 16'hFFF6;
    localparam logic [15:0]        SYNC_WORD     = 16'hFFF0;
    localparam logic [BYTE_W-1:0]  SYNC_HI_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0]  SYNC_LO_MASK  = 8'hF6;
    localparam logic [BYTE_W-1:0]  SYNC_LO_WORD  = 8'hF0;
    localparam logic [FULL_W-1:0]  VBR_FULLNESS  = 11'h7FF;
    localparam logic [LEN_W-1:0]   HDR_BYTES     = 13'd7;
    localparam logic [FNUM_W-1:0]  FNUM_MAX      = 16'hFFFF;
    localparam logic [CFG_W-1:0]   CFG_RESET     = 8'd32;

    localparam logic EVT_HEADER = 1'b0;
    localparam logic EVT_LOST   = 1'b1;

    typedef struct packed {
        logic                event_kind;
        logic                mpeg_version_bit;
        logic [1:0]          profile;
        logic [SFI_W-1:0]    sampling_index;
        logic [2:0]          channel_config;
        logic [LEN_W-1:0]    frame_length;
        logic [FULL_W-1:0]   buffer_fullness;
        logic [FNUM_W-1:0]   frame_number;
    } afsp_entry_t;

    // Length field of a captured 7-byte header
    function automatic logic [LEN_W-1:0] hdr_length(input logic [HDR_W-1:0] h);
        hdr_length = h[25:13];
    endfunction

    // Unpack a captured header into a queue entry
    function automatic afsp_entry_t hdr_fields(input logic [HDR_W-1:0] h);
        afsp_entry_t e;
        e.event_kind       = EVT_HEADER;
        e.mpeg_version_bit = h[43];
        e.profile          = h[39:38];
        e.sampling_index   = h[37:34];
        e.channel_config   = h[32:30];
        e.frame_length     = h[25:13];
        e.buffer_fullness  = h[12:2];
        e.frame_number     = '0;
        hdr_fields = e;
    endfunction

    // Sampling frequency table, zero for reserved indices
    function automatic logic [RATE_W-1:0] sample_rate(input logic [SFI_W-1:0] sfi);
        logic [RATE_W-1:0] r;
        case (sfi)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            4'd12:   r = 17'd7350;
            default: r = '0;
        endcase
        sample_rate = r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/afsp_in_if.sv @@
// Byte stream channel interface.
`default_nettype none

interface afsp_in_if;
    logic                          valid;
    logic                          ready;
    logic [afsp_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/afsp_out_if.sv @@
// Report channel interface carrying header and sync-lost transactions.
`default_nettype none

interface afsp_out_if;
    logic                              valid;
    logic                              ready;
    logic                              event_kind;
    logic                              mpeg_version_bit;
    logic [1:0]                        profile;
    logic [afsp_pkg::SFI_W-1:0]        sampling_index;
    logic [afsp_pkg::RATE_W-1:0]       sampling_rate;
    logic [2:0]                        channel_config;
    logic [afsp_pkg::LEN_W-1:0]        frame_length;
    logic [afsp_pkg::FULL_W-1:0]       buffer_fullness;
    logic                              is_vbr;
    logic [afsp_pkg::BITRATE_W-1:0]    bit_rate;
    logic [afsp_pkg::FNUM_W-1:0]       frame_number;
    logic                              stream_info_ready;

    modport source (
        output valid, input ready,
        output event_kind, output mpeg_version_bit, output profile,
        output sampling_index, output sampling_rate, output channel_config,
        output frame_length, output buffer_fullness, output is_vbr,
        output bit_rate, output frame_number, output stream_info_ready
    );
    modport sink (
        input valid, output ready,
        input event_kind, input mpeg_version_bit, input profile,
        input sampling_index, input sampling_rate, input channel_config,
        input frame_length, input buffer_fullness, input is_vbr,
        input bit_rate, input frame_number, input stream_info_ready
    );
endinterface

`default_nettype wire

@@ hdl/afsp_front.sv @@
// Sync hunt, header capture and frame length tracking; pushes events to the queue.
`default_nettype none

module afsp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_ready,
    input  wire logic [afsp_pkg::BYTE_W-1:0] data_byte,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output afsp_pkg::afsp_entry_t     push_data
);
    import afsp_pkg::*;

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_CAPTURE  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD  = 3'd2;
    localparam logic [2:0] PH_CHECK_HI = 3'd3;
    localparam logic [2:0] PH_CHECK_LO = 3'd4;

    logic [2:0]         phase_reg, phase_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    afsp_entry_t        pend_reg, pend_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               locked_reg, locked_next;
    logic [FNUM_W-1:0]  fcnt_reg, fcnt_next;

    logic               accept;
    logic [HDR_W-1:0]   hdr_shift;
    logic [LEN_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]   cap_len;
    logic [FNUM_W-1:0]  fcnt_inc;

    // Take a byte whenever the queue has room for its possible event
    assign byte_ready = push_ready;
    assign accept     = byte_valid && push_ready;

    assign hdr_shift = {hdr_reg[HDR_W-BYTE_W-1:0], data_byte};
    assign cnt_inc   = cnt_reg + LEN_W'(1);
    assign cap_len   = hdr_length(hdr_shift);
    assign fcnt_inc  = (fcnt_reg == FNUM_MAX) ? fcnt_reg : fcnt_reg + FNUM_W'(1);

    // Advance the parse phase by one byte
    always_comb
    begin
        phase_next  = phase_reg;
        prev_next   = prev_reg;
        hdr_next    = hdr_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        locked_next = locked_reg;
        fcnt_next   = fcnt_reg;
        push_valid  = 1'b0;
        push_data   = '0;

        if (accept)
        begin
            prev_next = data_byte;
            case (phase_reg)
                PH_HUNT:
                begin
                    if (({prev_reg, data_byte} & SYNC_MASK) == SYNC_WORD)
                    begin
                        hdr_next   = {{(HDR_W-2*BYTE_W){1'b0}}, prev_reg, data_byte};
                        cnt_next   = LEN_W'(2);
                        phase_next = PH_CAPTURE;
                    end
                end
                PH_CAPTURE:
                begin
                    hdr_next = hdr_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= HDR_BYTES)
                    begin
                        if (cap_len < HDR_BYTES)
                        begin
                            // Reject a short length as lost sync
                            if (locked_reg)
                            begin
                                locked_next          = 1'b0;
                                push_valid           = 1'b1;
                                push_data.event_kind = EVT_LOST;
                            end
                            phase_next = PH_HUNT;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            pend_next = hdr_fields(hdr_shift);
                            cnt_next  = HDR_BYTES;
                            if (locked_reg)
                            begin
                                fcnt_next              = fcnt_inc;
                                push_valid             = 1'b1;
                                push_data              = hdr_fields(hdr_shift);
                                push_data.frame_number = fcnt_inc;
                            end
                            phase_next = (cap_len == HDR_BYTES) ? PH_CHECK_HI : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= pend_reg.frame_length)
                    begin
                        phase_next = PH_CHECK_HI;
                    end
                end
                PH_CHECK_HI:
                begin
                    if (data_byte == SYNC_HI_BYTE)
                    begin
                        phase_next = PH_CHECK_LO;
                    end
                    else
                    begin
                        if (locked_reg)
                        begin
                            locked_next          = 1'b0;
                            push_valid           = 1'b1;
                            push_data.event_kind = EVT_LOST;
                        end
                        phase_next = PH_HUNT;
                        cnt_next   = '0;
                    end
                end
                PH_CHECK_LO:
                begin
                    if ((data_byte & SYNC_LO_MASK) == SYNC_LO_WORD)
                    begin
                        // Lock on the second good sync and report the first header
                        if (!locked_reg)
                        begin
                            locked_next            = 1'b1;
                            fcnt_next              = FNUM_W'(1);
                            push_valid             = 1'b1;
                            push_data              = pend_reg;
                            push_data.frame_number = FNUM_W'(1);
                        end
                        hdr_next   = {{(HDR_W-2*BYTE_W){1'b0}}, SYNC_HI_BYTE, data_byte};
                        cnt_next   = LEN_W'(2);
                        phase_next = PH_CAPTURE;
                    end
                    else
                    begin
                        if (locked_reg)
                        begin
                            locked_next          = 1'b0;
                            push_valid           = 1'b1;
                            push_data.event_kind = EVT_LOST;
                        end
                        phase_next = PH_HUNT;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            prev_reg   <= '0;
            hdr_reg    <= '0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            locked_reg <= 1'b0;
            fcnt_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            hdr_reg    <= hdr_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            locked_reg <= locked_next;
            fcnt_reg   <= fcnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/afsp_queue.sv @@
// Short event queue between the parser and the report formatter.
`default_nettype none

module afsp_queue #(
    parameter int DEPTH = afsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire afsp_pkg::afsp_entry_t push_data,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output afsp_pkg::afsp_entry_t      pop_data
);
    import afsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    afsp_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/afsp_back.sv @@
// Report formatter: sampling rate lookup, CBR bit rate and output register.
`default_nettype none

module afsp_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [afsp_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  wire afsp_pkg::afsp_entry_t  pop_data,
    afsp_out_if.source                  report
);
    import afsp_pkg::*;

    logic [CFG_W-1:0]      fcv_reg;
    logic                  out_valid_reg;
    afsp_entry_t           ent_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic                  vbr_reg;
    logic [BITRATE_W-1:0]  brate_reg;
    logic                  info_reg;

    logic                  load;
    logic                  is_hdr;
    logic [RATE_W-1:0]     rate;
    logic                  vbr;
    logic [RATE_W-11:0]    rate_k;
    logic [RATE_W-10+LEN_W-1:0] prod;
    logic [BITRATE_W-1:0]  brate;
    logic                  info;

    assign pop_ready = !out_valid_reg || report.ready;
    assign load      = pop_valid && pop_ready;

    // Derive the computed fields; a sync-lost entry reports zeros
    assign is_hdr = (pop_data.event_kind == EVT_HEADER);
    assign rate   = is_hdr ? sample_rate(pop_data.sampling_index) : '0;
    assign vbr    = is_hdr && (pop_data.buffer_fullness == VBR_FULLNESS);
    assign rate_k = rate[RATE_W-1:10];
    assign prod   = rate_k * pop_data.frame_length;
    assign brate  = vbr ? '0 : BITRATE_W'({prod, 3'b000});
    assign info   = is_hdr && (pop_data.frame_number >= FNUM_W'(fcv_reg));

    // Hold the configuration register and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcv_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fcv_reg <= cfg_wr_data;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg   <= pop_data;
            rate_reg  <= rate;
            vbr_reg   <= vbr;
            brate_reg <= brate;
            info_reg  <= info;
        end
    end

    assign report.valid             = out_valid_reg;
    assign report.event_kind        = ent_reg.event_kind;
    assign report.mpeg_version_bit  = ent_reg.mpeg_version_bit;
    assign report.profile           = ent_reg.profile;
    assign report.sampling_index    = ent_reg.sampling_index;
    assign report.sampling_rate     = rate_reg;
    assign report.channel_config    = ent_reg.channel_config;
    assign report.frame_length      = ent_reg.frame_length;
    assign report.buffer_fullness   = ent_reg.buffer_fullness;
    assign report.is_vbr            = vbr_reg;
    assign report.bit_rate          = brate_reg;
    assign report.frame_number      = ent_reg.frame_number;
    assign report.stream_info_ready = info_reg;

endmodule

`default_nettype wire

@@ hdl/adts_frame_sync_parser.sv @@
// Top level of the ADTS frame sync parser.
//
//   channel   dir   interface      transaction
//   stream    in    afsp_in_if     one ADTS byte
//   report    out   afsp_out_if    one header report or sync-lost event
//   cfg       in    wr_en/wr_data  info-ready frame threshold write
//
// Takes one byte per clock while the event queue is not full; the parser decides each
// byte in the cycle it is accepted. A report reaches the output through the event queue,
// then the formatter register with its 7x13 bit-rate multiply.
// Reset returns the parser to sync hunt, unlocked, and the info-ready threshold to 32.
// A stalled report channel fills the event queue; the stream side stalls only when
// the queue is full.
`default_nettype none

module adts_frame_sync_parser #(
    parameter int QUEUE_DEPTH = afsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [afsp_pkg::CFG_W-1:0]  cfg_wr_data,
    afsp_in_if.sink                          stream,
    afsp_out_if.source                       report
);
    import afsp_pkg::*;

    logic         push_valid, push_ready;
    afsp_entry_t  push_data;
    logic         pop_valid, pop_ready;
    afsp_entry_t  pop_data;

    afsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (stream.valid),
        .byte_ready (stream.ready),
        .data_byte  (stream.data_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    afsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    afsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .report      (report)
    );

endmodule

`default_nettype wire
